[hw/rtl/invcnt_pkg.sv]
// Shared constants and controller/datapath interface types for the inversion counter.
`default_nettype none

package invcnt_pkg;

  // Value range and sequence length limits.
  localparam int VALUE_BITS = 10;
  localparam int TREE_SIZE  = 1 << VALUE_BITS;
  localparam int MAX_LENGTH = 65536;

  // Fenwick node numbers run from 1 to TREE_SIZE. The update walk can step to
  // twice TREE_SIZE before it stops, so two extra bits are kept.
  localparam int NODE_BITS  = VALUE_BITS + 2;
  localparam int SEEN_BITS  = $clog2(MAX_LENGTH + 1);
  localparam int COUNT_BITS = SEEN_BITS;
  localparam int TOTAL_BITS = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // latch a new input beat and start the prefix walk
    logic prefix_step;  // issue the next prefix read
    logic add;          // add the count of earlier, greater values into the total
    logic upd_step;     // issue the next read-modify-write of the update walk
    logic set_ovf;      // mark the sequence as too long
    logic emit;         // load the result register and clear the sequence state
    logic clr_step;     // zero one tree node
  } invcnt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic node_zero;      // prefix walk has no node left
    logic node_past_end;  // update walk has left the tree
    logic acc_pend;       // a prefix read is still on its way back
    logic wr_pend;        // an update write-back is still due
    logic seen_full;      // the sequence has reached its maximum length
    logic last;           // the latched beat ends its sequence
    logic out_free;       // the result register can take a new result
    logic clr_last;       // the clearing pass is at its final node
  } invcnt_status_t;

endpackage

`default_nettype wire

[hw/rtl/inversion_counter.sv]
// Top level of the inversion counter: controller and datapath joined by command and status.
//
//   channel | direction | handshake            | fields
//   --------+-----------+----------------------+--------------------------------
//   in      | into      | in_valid / in_stall  | value[9:0], last
//   out     | out of    | out_valid / out_stall| inversions[31:0], overflow
//
// An element passes through dispatch, the prefix walk, the total update and the
// update walk before the next one is accepted. The prefix walk visits p nodes, p
// being the number of set bits of value + 1, and the update walk visits u nodes;
// p + u is at most 12. The Fenwick tree memory has one read port and one write
// port: each walk reads one node per cycle, and the update walk writes a node back
// while it reads the next. An element beyond the maximum length skips both walks.
// After the element marked last the tree is zeroed in a clearing pass over all
// 1024 nodes, and reset starts the same pass; in_stall stays high throughout.
// The result sits in its own output register, so a stall on the out side holds
// only the finishing step and never the clearing pass already under way.
`default_nettype none

module inversion_counter
  import invcnt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  last,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [TOTAL_BITS-1:0]      inversions,
  output logic                       overflow
);

  invcnt_cmd_t    cmd;
  invcnt_status_t status;

  // The controller walks each element through dispatch, the prefix read walk,
  // the total update and the increment walk.
  invcnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the tree memory, the walk pointer, the running totals
  // and the result register.
  invcnt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .last       (last),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .inversions (inversions),
    .overflow   (overflow),
    .cmd        (cmd),
    .status     (status)
  );

  // Once a beat is accepted the block is busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // A fresh result only appears while the block is busy clearing its tree.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_stall)
    else $error("result appeared while the block was idle");

  // The controller never loads the result register while it still holds a beat.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result register overwritten");

endmodule

`default_nettype wire

[hw/rtl/invcnt_ctrl.sv]
// Controller state machine for the inversion counter.
`default_nettype none

module invcnt_ctrl
  import invcnt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire invcnt_status_t status,
  output invcnt_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_PREFIX   = 3'd3;
  localparam logic [2:0] S_ADD      = 3'd4;
  localparam logic [2:0] S_UPDATE   = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.seen_full) begin
          cmd.set_ovf = 1'b1;
          state_next  = status.last ? S_FINISH : S_IDLE;
        end else begin
          state_next = S_PREFIX;
        end
      end
      S_PREFIX: begin
        cmd.prefix_step = 1'b1;
        if (status.node_zero && !status.acc_pend) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd_step = 1'b1;
        if (status.node_past_end && !status.wr_pend) begin
          state_next = status.last ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_CLEAR;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

[hw/rtl/invcnt_dp.sv]
// Datapath of the inversion counter: Fenwick tree memory, walk pointer, totals and result register.
`default_nettype none

module invcnt_dp
  import invcnt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  last,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic [TOTAL_BITS-1:0]      inversions,
  output logic                       overflow,
  input  wire invcnt_cmd_t           cmd,
  output invcnt_status_t             status
);

  // Tree nodes 1..TREE_SIZE live at addresses 0..TREE_SIZE-1.
  logic [COUNT_BITS-1:0] mem [TREE_SIZE];
  logic [COUNT_BITS-1:0] rdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [VALUE_BITS-1:0] mem_waddr;
  logic [VALUE_BITS-1:0] mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  logic [VALUE_BITS-1:0] value_q;
  logic                  last_q;
  logic [NODE_BITS-1:0]  node;
  logic [NODE_BITS-1:0]  node_low;
  logic [NODE_BITS-1:0]  node_start;
  logic                  node_in_tree;
  logic                  acc_pend;
  logic                  wr_pend;
  logic [VALUE_BITS-1:0] wr_addr;
  logic [COUNT_BITS-1:0] psum;
  logic [SEEN_BITS-1:0]  seen_count;
  logic [TOTAL_BITS-1:0] running_total;
  logic                  length_overflow;
  logic [VALUE_BITS-1:0] clr_addr;

  logic [COUNT_BITS-1:0] greater;
  logic [TOTAL_BITS:0]   total_sum;
  logic [TOTAL_BITS-1:0] total_next;

  assign node_low     = node & (~node + 1'b1);
  assign node_start   = NODE_BITS'(value) + 1'b1;
  assign node_in_tree = (node != '0) && (node <= NODE_BITS'(TREE_SIZE));

  assign greater    = seen_count - psum;
  assign total_sum  = {1'b0, running_total} + (TOTAL_BITS + 1)'(greater);
  assign total_next = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];

  // Memory port control. Reads and writes never collide on one address:
  // the update walk writes a node while it reads the next, higher node.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = VALUE_BITS'(node - 1'b1);
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = rdata + 1'b1;
    if ((cmd.prefix_step || cmd.upd_step) && node_in_tree) begin
      mem_re = 1'b1;
    end
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (wr_pend) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Walk pointer and payload latches.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_q <= value;
      last_q  <= last;
      node    <= node_start;
      psum    <= '0;
    end else if (cmd.add) begin
      node <= NODE_BITS'(value_q) + 1'b1;
    end else if (cmd.prefix_step && node_in_tree) begin
      node <= node - node_low;
    end else if (cmd.upd_step && node_in_tree) begin
      node    <= node + node_low;
      wr_addr <= mem_raddr;
    end
    if (acc_pend) begin
      psum <= psum + rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend        <= 1'b0;
      wr_pend         <= 1'b0;
      seen_count      <= '0;
      running_total   <= '0;
      length_overflow <= 1'b0;
      clr_addr        <= '0;
      out_valid       <= 1'b0;
    end else begin
      acc_pend <= cmd.prefix_step && node_in_tree;
      wr_pend  <= cmd.upd_step && node_in_tree;
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.add) begin
        running_total <= total_next;
        seen_count    <= seen_count + 1'b1;
      end
      if (cmd.set_ovf) begin
        length_overflow <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid       <= 1'b1;
        running_total   <= '0;
        seen_count      <= '0;
        length_overflow <= 1'b0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      inversions <= running_total;
      overflow   <= length_overflow;
    end
  end

  always_comb begin
    status.node_zero     = (node == '0);
    status.node_past_end = (node > NODE_BITS'(TREE_SIZE));
    status.acc_pend      = acc_pend;
    status.wr_pend       = wr_pend;
    status.seen_full     = (seen_count >= SEEN_BITS'(MAX_LENGTH));
    status.last          = last_q;
    status.out_free      = !out_valid || !out_stall;
    status.clr_last      = (clr_addr == '1);
  end

endmodule

`default_nettype wire
